// ===== design/assert_macros.svh =====
// assertion macros shared by the speed controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition on one edge implies a condition on the next edge
`define PSC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/psc_pkg.sv =====
// shared types, widths and constants of the speed controller
package psc_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int SPEED_W    = 16;
  localparam int MS_W       = 16;
  localparam int TARGET_W   = 17;
  localparam int ERR_W      = 17;
  localparam int SUM_W      = 21;
  localparam int PREV_W     = 18;
  localparam int DERIV_W    = 18;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 20;
  localparam int RATE_W     = 16;
  localparam int POWER_W    = 7;
  localparam int RAMP_FRAC  = 10;
  localparam int SP_W       = SPEED_W + RAMP_FRAC;
  localparam int STEP_W     = RATE_W + MS_W;
  localparam int SUM_SHIFT  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
  localparam int ACC_W    = PROD_I_W + 2;

  localparam logic [SPEED_W-1:0] TARGET_MAX = SPEED_W'(2100 * 16);
  localparam logic [POWER_W-1:0] POWER_MAX  = POWER_W'(127);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_P         = 3'd0;
  localparam cfg_idx_t REG_GAIN_I         = 3'd1;
  localparam cfg_idx_t REG_GAIN_D         = 3'd2;
  localparam cfg_idx_t REG_INTEGRAL_LIMIT = 3'd3;
  localparam cfg_idx_t REG_RAMP_RATE      = 3'd4;
  localparam cfg_idx_t REG_DEADBAND_POWER = 3'd5;
  localparam cfg_idx_t REG_DEADBAND_SPEED = 3'd6;
  localparam cfg_idx_t REG_OVERLOAD_LEVEL = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [RATE_W-1:0]  ramp_rate;
    logic [POWER_W-1:0] deadband_power;
    logic [SPEED_W-1:0] deadband_speed;
    logic [SPEED_W-1:0] overload_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:         GAIN_W'(2048),
    gain_i:         GAIN_W'(41),
    gain_d:         GAIN_W'(0),
    integral_limit: LIMIT_W'(480000),
    ramp_rate:      RATE_W'(19661),
    deadband_power: POWER_W'(30),
    deadband_speed: SPEED_W'(1920),
    overload_level: SPEED_W'(4800)
  };

  // error terms after the state update
  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic                      disabled;
    logic                      low_speed;
    logic                      over;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   err_sum;
    logic signed [DERIV_W-1:0] deriv;
  } upd_t;

  // weighted terms ready for the final sum
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic                       disabled;
    logic                       low_speed;
    logic                       over;
    logic signed [ERR_W-1:0]    err;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
  } prd_t;

endpackage

// ===== design/pid_speed_controller.sv =====
// pid speed controller with setpoint ramp: top level
//
// Input channel: in_valid/in_stall carry one control tick per word (channel,
// enable, target and measured speed in 1/16 rpm, elapsed ms). A word is taken
// at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall carry one result word per tick (channel,
// drive power 0..127, speed error, overload and disabled flags), in order.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index at the edge;
// write only while no tick is in flight.
// A taken tick passes the input word, error terms and gain products registers,
// and the result register presents its result word. Throughput: one tick per
// cycle while in_stall is low; the per-channel ramp and integral state is read
// and written in a single stage, so ticks of one channel may follow back to back.
// The stages are input word, error terms, gain products and result register.
// Stall: out_stall holds the result register; the stages behind it keep
// filling, and in_stall rises only when every stage holds a word.
// Reset (rst_n low, synchronous): registers return to defaults, ramp,
// integral and derivative state of all channels clear, no word is valid.
module pid_speed_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [psc_pkg::CH_W-1:0]            in_channel,
  input  logic                                in_enable,
  input  logic signed [psc_pkg::TARGET_W-1:0] in_target_speed,
  input  logic [psc_pkg::SPEED_W-1:0]         in_measured_speed,
  input  logic [psc_pkg::MS_W-1:0]            in_elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psc_pkg::CH_W-1:0]            out_channel,
  output logic [psc_pkg::POWER_W-1:0]         out_drive_power,
  output logic signed [psc_pkg::ERR_W-1:0]    out_speed_error,
  output logic                                out_overloaded,
  output logic                                out_disabled
);

  psc_pkg::cfg_t cfg;
  logic          upd_valid;
  psc_pkg::upd_t upd;
  logic          upd_take;
  logic          prd_valid;
  psc_pkg::prd_t prd;
  logic          prd_take;

  psc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psc_update u_update (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_enable         (in_enable),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .in_elapsed_ms     (in_elapsed_ms),
    .upd_valid         (upd_valid),
    .upd               (upd),
    .upd_take          (upd_take)
  );

  psc_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .upd_valid (upd_valid),
    .upd       (upd),
    .upd_take  (upd_take),
    .prd_valid (prd_valid),
    .prd       (prd),
    .prd_take  (prd_take)
  );

  psc_output u_output (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .prd_valid       (prd_valid),
    .prd             (prd),
    .prd_take        (prd_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_drive_power (out_drive_power),
    .out_speed_error (out_speed_error),
    .out_overloaded  (out_overloaded),
    .out_disabled    (out_disabled)
  );

endmodule

// ===== design/psc_cfg.sv =====
// configuration register file of the speed controller
module psc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psc_pkg::cfg_t                   cfg
);

  psc_pkg::cfg_t cfg_r;
  psc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        psc_pkg::REG_GAIN_P: begin
          cfg_nxt.gain_p = cfg_data[psc_pkg::GAIN_W-1:0];
        end
        psc_pkg::REG_GAIN_I: begin
          cfg_nxt.gain_i = cfg_data[psc_pkg::GAIN_W-1:0];
        end
        psc_pkg::REG_GAIN_D: begin
          cfg_nxt.gain_d = cfg_data[psc_pkg::GAIN_W-1:0];
        end
        psc_pkg::REG_INTEGRAL_LIMIT: begin
          cfg_nxt.integral_limit = cfg_data[psc_pkg::LIMIT_W-1:0];
        end
        psc_pkg::REG_RAMP_RATE: begin
          cfg_nxt.ramp_rate = cfg_data[psc_pkg::RATE_W-1:0];
        end
        psc_pkg::REG_DEADBAND_POWER: begin
          cfg_nxt.deadband_power = cfg_data[psc_pkg::POWER_W-1:0];
        end
        psc_pkg::REG_DEADBAND_SPEED: begin
          cfg_nxt.deadband_speed = cfg_data[psc_pkg::SPEED_W-1:0];
        end
        psc_pkg::REG_OVERLOAD_LEVEL: begin
          cfg_nxt.overload_level = cfg_data[psc_pkg::SPEED_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= psc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/psc_update.sv =====
// input register, per-channel ramp and error state, error terms register
`include "assert_macros.svh"

module psc_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psc_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [psc_pkg::CH_W-1:0]            in_channel,
  input  logic                                in_enable,
  input  logic signed [psc_pkg::TARGET_W-1:0] in_target_speed,
  input  logic [psc_pkg::SPEED_W-1:0]         in_measured_speed,
  input  logic [psc_pkg::MS_W-1:0]            in_elapsed_ms,
  output logic                                upd_valid,
  output psc_pkg::upd_t                       upd,
  input  logic                                upd_take
);

  localparam int SUM_X_W = psc_pkg::SUM_W + 1;
  localparam int OVR_W   = psc_pkg::ERR_W + 2;

  // input word register
  logic                                s1_valid_r;
  logic [psc_pkg::CH_W-1:0]            s1_ch_r;
  logic                                s1_en_r;
  logic signed [psc_pkg::TARGET_W-1:0] s1_tgt_r;
  logic [psc_pkg::SPEED_W-1:0]         s1_meas_r;
  logic [psc_pkg::STEP_W-1:0]          s1_step_r;
  logic [psc_pkg::STEP_W-1:0]          step_nxt;

  // error terms register
  logic          upd_valid_r;
  psc_pkg::upd_t upd_r;
  psc_pkg::upd_t upd_nxt;

  // per-channel state
  logic [psc_pkg::SP_W-1:0]          sp_r   [psc_pkg::CHANNELS];
  logic signed [psc_pkg::SUM_W-1:0]  esum_r [psc_pkg::CHANNELS];
  logic signed [psc_pkg::PREV_W-1:0] prev_r [psc_pkg::CHANNELS];
  logic [psc_pkg::SP_W-1:0]          sp_nxt;
  logic signed [psc_pkg::SUM_W-1:0]  esum_nxt;
  logic signed [psc_pkg::PREV_W-1:0] prev_nxt;

  logic                              s1_load;
  logic                              s2_load;
  logic                              ch_ok;
  logic                              run;
  logic                              st_wr;
  logic [psc_pkg::SPEED_W-1:0]       tgt_clamp;
  logic [psc_pkg::SP_W-1:0]          tgt_fx;
  logic [psc_pkg::SP_W-1:0]          sp_cur;
  logic [psc_pkg::STEP_W:0]          sp_sum;
  logic [psc_pkg::SPEED_W-1:0]       sp_int;
  logic signed [psc_pkg::ERR_W:0]    err_full;
  logic signed [psc_pkg::ERR_W-1:0]  err;
  logic signed [psc_pkg::PREV_W-1:0] err_x;
  logic signed [SUM_X_W-1:0]         esum_raw;
  logic signed [SUM_X_W-1:0]         lim_pos;
  logic signed [SUM_X_W-1:0]         lim_neg;
  logic signed [SUM_X_W-1:0]         esum_clamp;
  logic signed [psc_pkg::DERIV_W-1:0] deriv;
  logic signed [OVR_W-1:0]           ovr_sum;

  assign s2_load  = !upd_valid_r || upd_take;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;
  assign step_nxt = cfg.ramp_rate * in_elapsed_ms;

  always_comb begin
    ch_ok = ((psc_pkg::CH_W + 1)'(s1_ch_r) < (psc_pkg::CH_W + 1)'(psc_pkg::CHANNELS));
    run   = ch_ok && s1_en_r;

    // negative targets go to zero, large ones to full speed
    if (s1_tgt_r[psc_pkg::TARGET_W-1]) begin
      tgt_clamp = '0;
    end else if (s1_tgt_r[psc_pkg::SPEED_W-1:0] > psc_pkg::TARGET_MAX) begin
      tgt_clamp = psc_pkg::TARGET_MAX;
    end else begin
      tgt_clamp = s1_tgt_r[psc_pkg::SPEED_W-1:0];
    end
    tgt_fx = {tgt_clamp, {psc_pkg::RAMP_FRAC{1'b0}}};

    sp_cur = sp_r[s1_ch_r];
    sp_sum = (psc_pkg::STEP_W + 1)'(sp_cur) + (psc_pkg::STEP_W + 1)'(s1_step_r);

    // setpoint snaps down at once, rises at most to the target
    if (tgt_fx <= sp_cur) begin
      sp_nxt = tgt_fx;
    end else if (sp_sum > (psc_pkg::STEP_W + 1)'(tgt_fx)) begin
      sp_nxt = tgt_fx;
    end else begin
      sp_nxt = sp_sum[psc_pkg::SP_W-1:0];
    end

    sp_int   = sp_nxt[psc_pkg::SP_W-1:psc_pkg::RAMP_FRAC];
    err_full = $signed({2'b00, s1_meas_r}) - $signed({2'b00, sp_int});
    err      = err_full[psc_pkg::ERR_W-1:0];
    err_x    = psc_pkg::PREV_W'(err);

    esum_raw = SUM_X_W'(esum_r[s1_ch_r]) + SUM_X_W'(err);
    lim_pos  = $signed({{(SUM_X_W - psc_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});
    lim_neg  = -lim_pos;
    if (esum_raw > lim_pos) begin
      esum_clamp = lim_pos;
    end else if (esum_raw < lim_neg) begin
      esum_clamp = lim_neg;
    end else begin
      esum_clamp = esum_raw;
    end
    if (cfg.gain_i == '0) begin
      esum_nxt = '0;
    end else begin
      esum_nxt = esum_clamp[psc_pkg::SUM_W-1:0];
    end

    if (cfg.gain_d == '0) begin
      deriv    = '0;
      prev_nxt = prev_r[s1_ch_r];
    end else begin
      deriv    = psc_pkg::DERIV_W'(err_x - prev_r[s1_ch_r]);
      prev_nxt = err_x;
    end

    // overload when err + level <= 0
    ovr_sum = OVR_W'(err) + $signed({2'b00, cfg.overload_level});

    upd_nxt.channel = s1_ch_r;
    if (run) begin
      upd_nxt.disabled  = 1'b0;
      upd_nxt.low_speed = (s1_meas_r < cfg.deadband_speed);
      upd_nxt.over      = (ovr_sum <= 0);
      upd_nxt.err       = err;
      upd_nxt.err_sum   = esum_nxt;
      upd_nxt.deriv     = deriv;
    end else begin
      upd_nxt.disabled  = 1'b1;
      upd_nxt.low_speed = 1'b0;
      upd_nxt.over      = 1'b0;
      upd_nxt.err       = '0;
      upd_nxt.err_sum   = '0;
      upd_nxt.deriv     = '0;
    end

    st_wr = s2_load && s1_valid_r && ch_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      upd_valid_r <= 1'b0;
      for (int c = 0; c < psc_pkg::CHANNELS; c++) begin
        sp_r[c]   <= '0;
        esum_r[c] <= '0;
        prev_r[c] <= '0;
      end
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        upd_valid_r <= s1_valid_r;
      end
      if (st_wr) begin
        if (s1_en_r) begin
          sp_r[s1_ch_r]   <= sp_nxt;
          esum_r[s1_ch_r] <= esum_nxt;
          prev_r[s1_ch_r] <= prev_nxt;
        end else begin
          esum_r[s1_ch_r] <= '0;
          prev_r[s1_ch_r] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_ch_r   <= in_channel;
      s1_en_r   <= in_enable;
      s1_tgt_r  <= in_target_speed;
      s1_meas_r <= in_measured_speed;
      s1_step_r <= step_nxt;
    end
    if (s2_load && s1_valid_r) begin
      upd_r <= upd_nxt;
    end
  end

  assign upd_valid = upd_valid_r;
  assign upd       = upd_r;

  `PSC_ASSERT(a_dis_clear, upd_valid_r && upd_r.disabled |-> upd_r.err == '0 && !upd_r.over, "disabled word carries error terms")
  `PSC_ASSERT_NEXT(a_isum_zero, s2_load && s1_valid_r && cfg.gain_i == '0, upd_r.err_sum == '0, "integral not cleared with zero gain")
  `PSC_ASSERT_NEXT(a_hold, upd_valid_r && !upd_take, upd_valid_r && $stable(upd_r), "error terms lost while held")

endmodule

// ===== design/psc_mult.sv =====
// gain multiplication stage of the speed controller
module psc_mult (
  input  logic          clk,
  input  logic          rst_n,
  input  psc_pkg::cfg_t cfg,
  input  logic          upd_valid,
  input  psc_pkg::upd_t upd,
  output logic          upd_take,
  output logic          prd_valid,
  output psc_pkg::prd_t prd,
  input  logic          prd_take
);

  logic          prd_valid_r;
  psc_pkg::prd_t prd_r;
  psc_pkg::prd_t prd_nxt;
  logic          load;

  assign load     = !prd_valid_r || prd_take;
  assign upd_take = load;

  always_comb begin
    prd_nxt.channel   = upd.channel;
    prd_nxt.disabled  = upd.disabled;
    prd_nxt.low_speed = upd.low_speed;
    prd_nxt.over      = upd.over;
    prd_nxt.err       = upd.err;
    prd_nxt.prod_p    = $signed({1'b0, cfg.gain_p}) * upd.err;
    prd_nxt.prod_i    = $signed({1'b0, cfg.gain_i}) * upd.err_sum;
    prd_nxt.prod_d    = $signed({1'b0, cfg.gain_d}) * upd.deriv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_valid_r <= 1'b0;
    end else if (load) begin
      prd_valid_r <= upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && upd_valid) begin
      prd_r <= prd_nxt;
    end
  end

  assign prd_valid = prd_valid_r;
  assign prd       = prd_r;

endmodule

// ===== design/psc_output.sv =====
// pid sum, power clamp, deadband and result register
`include "assert_macros.svh"

module psc_output (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psc_pkg::cfg_t                       cfg,
  input  logic                                prd_valid,
  input  psc_pkg::prd_t                       prd,
  output logic                                prd_take,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psc_pkg::CH_W-1:0]            out_channel,
  output logic [psc_pkg::POWER_W-1:0]         out_drive_power,
  output logic signed [psc_pkg::ERR_W-1:0]    out_speed_error,
  output logic                                out_overloaded,
  output logic                                out_disabled
);

  localparam int SHR_W = psc_pkg::ACC_W - psc_pkg::SUM_SHIFT;

  logic                                out_valid_r;
  logic [psc_pkg::CH_W-1:0]            channel_r;
  logic [psc_pkg::POWER_W-1:0]         power_r;
  logic signed [psc_pkg::ERR_W-1:0]    err_r;
  logic                                over_r;
  logic                                disabled_r;
  logic [psc_pkg::POWER_W-1:0]         power_nxt;

  logic                                load;
  logic signed [psc_pkg::ACC_W-1:0]    acc;
  logic signed [psc_pkg::ACC_W-1:0]    neg;
  logic [SHR_W-1:0]                    shr;
  logic [psc_pkg::POWER_W-1:0]         power_clamp;

  assign load     = !out_valid_r || !out_stall;
  assign prd_take = load;

  always_comb begin
    acc = psc_pkg::ACC_W'(prd.prod_p) + psc_pkg::ACC_W'(prd.prod_i)
        + psc_pkg::ACC_W'(prd.prod_d);
    neg = -acc;
    shr = neg[psc_pkg::ACC_W-1:psc_pkg::SUM_SHIFT];
    if (neg <= 0) begin
      power_clamp = '0;
    end else if (shr > SHR_W'(psc_pkg::POWER_MAX)) begin
      power_clamp = psc_pkg::POWER_MAX;
    end else begin
      power_clamp = shr[psc_pkg::POWER_W-1:0];
    end
    // small positive drive at low speed is raised to the deadband power
    if (power_clamp != '0 && power_clamp < cfg.deadband_power && prd.low_speed) begin
      power_nxt = cfg.deadband_power;
    end else begin
      power_nxt = power_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= prd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && prd_valid) begin
      channel_r  <= prd.channel;
      power_r    <= power_nxt;
      err_r      <= prd.err;
      over_r     <= prd.over;
      disabled_r <= prd.disabled;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = channel_r;
  assign out_drive_power = power_r;
  assign out_speed_error = err_r;
  assign out_overloaded  = over_r;
  assign out_disabled    = disabled_r;

  `PSC_ASSERT(a_dis_power, out_valid_r && disabled_r |-> power_r == '0 && err_r == '0 && !over_r, "disabled word with drive")

endmodule

// ===== tb/sv/pid_speed_controller_tb.sv =====
// testbench for the pid speed controller: directed ticks, register sweeps, random control runs
module pid_speed_controller_tb;

  localparam int PERIOD = 8;
  localparam int PIPE_LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic [psc_pkg::CH_W-1:0]            channel;
    logic                                enable;
    logic signed [psc_pkg::TARGET_W-1:0] target;
    logic [psc_pkg::SPEED_W-1:0]         measured_speed;
    logic [psc_pkg::MS_W-1:0]            elapsed_ms;
  } tick_t;

  typedef struct {
    logic [psc_pkg::CH_W-1:0]         channel;
    logic [psc_pkg::POWER_W-1:0]      power;
    logic signed [psc_pkg::ERR_W-1:0] speed_error;
    logic                             overloaded;
    logic                             disabled;
  } result_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                cfg_wr_en = 1'b0;
  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [psc_pkg::CH_W-1:0]            in_channel = '0;
  logic                                in_enable = 1'b0;
  logic signed [psc_pkg::TARGET_W-1:0] in_target_speed = '0;
  logic [psc_pkg::SPEED_W-1:0]         in_measured_speed = '0;
  logic [psc_pkg::MS_W-1:0]            in_elapsed_ms = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [psc_pkg::CH_W-1:0]            out_channel;
  logic [psc_pkg::POWER_W-1:0]         out_drive_power;
  logic signed [psc_pkg::ERR_W-1:0]    out_speed_error;
  logic                                out_overloaded;
  logic                                out_disabled;

  // controller state and registers as the predictor sees them
  psc_pkg::cfg_t model_cfg = psc_pkg::CFG_RESET;
  longint ramp_fx [psc_pkg::CHANNELS];
  longint err_acc [psc_pkg::CHANNELS];
  longint err_prev [psc_pkg::CHANNELS];

  result_t     expected_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          hold_len = 0;

  pid_speed_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_enable         (in_enable),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .out_drive_power   (out_drive_power),
    .out_speed_error   (out_speed_error),
    .out_overloaded    (out_overloaded),
    .out_disabled      (out_disabled)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly short runs, now and then a long one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (!tx_idle || $urandom_range(0, 1) == 0) return 0;
    return pick_len();
  endfunction

  function automatic result_t predict_control(tick_t t);
    longint tgt, tgt_fx, rise, e, s, d, acc, lim, pw;
    int c;
    result_t r;
    c = int'(t.channel);
    r.channel = t.channel;
    r.power = '0;
    r.speed_error = '0;
    r.overloaded = 1'b0;
    r.disabled = 1'b1;
    if (!t.enable) begin
      err_acc[c] = 0;
      err_prev[c] = 0;
      return r;
    end
    tgt = longint'(t.target);
    if (tgt < 0) tgt = 0;
    if (tgt > longint'(psc_pkg::TARGET_MAX)) tgt = longint'(psc_pkg::TARGET_MAX);
    tgt_fx = tgt << psc_pkg::RAMP_FRAC;
    // setpoint drops at once, rises by the ramp and never past the target
    if (tgt_fx <= ramp_fx[c]) begin
      ramp_fx[c] = tgt_fx;
    end else begin
      rise = ramp_fx[c] + longint'(model_cfg.ramp_rate) * longint'(t.elapsed_ms);
      ramp_fx[c] = (rise > tgt_fx) ? tgt_fx : rise;
    end
    e = longint'(t.measured_speed) - (ramp_fx[c] >>> psc_pkg::RAMP_FRAC);
    lim = longint'(model_cfg.integral_limit);
    if (model_cfg.gain_i != 0) begin
      s = err_acc[c] + e;
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      err_acc[c] = s;
    end else begin
      err_acc[c] = 0;
    end
    // previous error is only tracked while the derivative gain is live
    if (model_cfg.gain_d != 0) begin
      d = e - err_prev[c];
      err_prev[c] = e;
    end else begin
      d = 0;
    end
    acc = -(longint'(model_cfg.gain_p) * e + longint'(model_cfg.gain_i) * err_acc[c]
            + longint'(model_cfg.gain_d) * d);
    pw = 0;
    if (acc > 0) begin
      pw = acc >>> psc_pkg::SUM_SHIFT;
      if (pw > longint'(psc_pkg::POWER_MAX)) pw = longint'(psc_pkg::POWER_MAX);
    end
    if (pw > 0 && pw < longint'(model_cfg.deadband_power)
        && longint'(t.measured_speed) < longint'(model_cfg.deadband_speed))
      pw = longint'(model_cfg.deadband_power);
    r.power = psc_pkg::POWER_W'(pw);
    r.speed_error = psc_pkg::ERR_W'(e);
    r.overloaded = (e <= -longint'(model_cfg.overload_level));
    r.disabled = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // result side: random stall runs, plus a long hold when one is requested
  always @(posedge clk) begin : stall_driver
    int hold_cnt;
    int run_left;
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (run_left != 0) begin
      run_left--;
    end else if (rx_idle && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      run_left = pick_len();
    end else begin
      out_stall <= 1'b0;
      run_left = rx_idle ? $urandom_range(0, 4) : 0;
    end
  end

  always @(posedge clk) begin : result_checker
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_channel !== want.channel)
          report_mismatch($sformatf("channel %0d, want %0d", out_channel, want.channel));
        if (out_drive_power !== want.power)
          report_mismatch($sformatf("power %0d, want %0d", out_drive_power, want.power));
        if (out_speed_error !== want.speed_error)
          report_mismatch($sformatf("error %0d, want %0d", out_speed_error,
                                    want.speed_error));
        if (out_overloaded !== want.overloaded)
          report_mismatch($sformatf("overload %b, want %b", out_overloaded,
                                    want.overloaded));
        if (out_disabled !== want.disabled)
          report_mismatch($sformatf("disabled %b, want %b", out_disabled, want.disabled));
      end
      results_seen++;
    end
  end

  task automatic send_tick(tick_t t);
    int gap;
    in_valid <= 1'b1;
    in_channel <= t.channel;
    in_enable <= t.enable;
    in_target_speed <= t.target;
    in_measured_speed <= t.measured_speed;
    in_elapsed_ms <= t.elapsed_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_control(t));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(int ch, int en, int tgt, int meas, int ms);
    tick_t t;
    t.channel = psc_pkg::CH_W'(ch);
    t.enable = en[0];
    t.target = psc_pkg::TARGET_W'(tgt);
    t.measured_speed = psc_pkg::SPEED_W'(meas);
    t.elapsed_ms = psc_pkg::MS_W'(ms);
    send_tick(t);
  endtask

  // sender pauses until every outstanding result word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic put_reg(psc_pkg::cfg_idx_t idx, logic [psc_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(psc_pkg::cfg_t s);
    settle();
    put_reg(psc_pkg::REG_GAIN_P, psc_pkg::CFG_DATA_W'(s.gain_p));
    put_reg(psc_pkg::REG_GAIN_I, psc_pkg::CFG_DATA_W'(s.gain_i));
    put_reg(psc_pkg::REG_GAIN_D, psc_pkg::CFG_DATA_W'(s.gain_d));
    put_reg(psc_pkg::REG_INTEGRAL_LIMIT, psc_pkg::CFG_DATA_W'(s.integral_limit));
    put_reg(psc_pkg::REG_RAMP_RATE, psc_pkg::CFG_DATA_W'(s.ramp_rate));
    put_reg(psc_pkg::REG_DEADBAND_POWER, psc_pkg::CFG_DATA_W'(s.deadband_power));
    put_reg(psc_pkg::REG_DEADBAND_SPEED, psc_pkg::CFG_DATA_W'(s.deadband_speed));
    put_reg(psc_pkg::REG_OVERLOAD_LEVEL, psc_pkg::CFG_DATA_W'(s.overload_level));
    cfg_wr_en <= 1'b0;
    model_cfg = s;
  endtask

  function automatic psc_pkg::cfg_t random_settings();
    psc_pkg::cfg_t s;
    s.gain_p = psc_pkg::GAIN_W'($urandom);
    s.gain_i = ($urandom_range(0, 3) == 0) ? '0
                                           : psc_pkg::GAIN_W'($urandom_range(1, 2000));
    s.gain_d = ($urandom_range(0, 3) == 0) ? '0 : psc_pkg::GAIN_W'($urandom);
    s.integral_limit = psc_pkg::LIMIT_W'($urandom);
    s.ramp_rate = psc_pkg::RATE_W'($urandom);
    s.deadband_power = psc_pkg::POWER_W'($urandom);
    s.deadband_speed = psc_pkg::SPEED_W'($urandom);
    s.overload_level = psc_pkg::SPEED_W'($urandom);
    return s;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.channel = psc_pkg::CH_W'($urandom);
    t.enable = 1'($urandom_range(0, 1));
    t.target = psc_pkg::TARGET_W'($urandom);
    t.measured_speed = psc_pkg::SPEED_W'($urandom);
    t.elapsed_ms = psc_pkg::MS_W'($urandom);
    return t;
  endfunction

  // runs of ticks holding one target while the speed drifts, with some noise mixed in
  task automatic run_control(int count);
    tick_t t;
    int sent, run, ch, tgt, meas;
    sent = 0;
    while (sent < count) begin
      run = $urandom_range(5, 50);
      ch = $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0)
        tgt = $urandom_range(0, 1) ? int'($urandom_range(33601, 65535))
                                   : -int'($urandom_range(1, 65536));
      else
        tgt = int'($urandom_range(0, 33600));
      meas = $urandom_range(0, 34000);
      for (int i = 0; i < run && sent < count; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          t = noise_tick();
        end else begin
          if ($urandom_range(0, 4) == 0) ch = 1 - ch;
          meas = meas + int'($urandom_range(0, 800)) - 400;
          if (meas < 0) meas = 0;
          if (meas > 65535) meas = 65535;
          t.channel = psc_pkg::CH_W'(ch);
          t.enable = ($urandom_range(0, 19) != 0);
          t.target = psc_pkg::TARGET_W'(tgt);
          t.measured_speed = psc_pkg::SPEED_W'(meas);
          t.elapsed_ms = ($urandom_range(0, 15) == 0)
                         ? psc_pkg::MS_W'($urandom)
                         : psc_pkg::MS_W'($urandom_range(1, 100));
        end
        send_tick(t);
        sent++;
      end
    end
  endtask

  task automatic test_edge_ticks();
    psc_pkg::cfg_t s;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_fields(0, 1, -65536, 0, 0);      // negative target clamps to zero
    send_fields(0, 1, 65535, 0, 1);       // target above the top speed
    send_fields(0, 1, 65535, 0, 65535);   // huge ramp step capped at the target
    send_fields(0, 1, 100, 0, 10);        // setpoint snaps down
    send_fields(1, 1, 33600, 65535, 10);  // running fast: drive sum goes negative
    send_fields(1, 1, 200, 100, 1000);
    send_fields(1, 1, 200, 150, 10);      // low speed, but the integral from the fast run keeps the drive at zero
    send_fields(1, 0, -1, 65535, 65535);  // disabled word
    send_fields(0, 0, 0, 0, 0);
    send_fields(0, 1, 0, 0, 0);
    send_fields(1, 1, 33600, 0, 65535);
    send_fields(1, 1, 33600, 33600, 5);
    send_fields(0, 1, -1, 65535, 0);
    send_fields(0, 1, 32768, 1919, 3);
    send_fields(0, 1, 65535, 1920, 65535);
    // derivative on, integral off
    s = psc_pkg::CFG_RESET;
    s.gain_i = '0;
    s.gain_d = psc_pkg::GAIN_W'(4096);
    s.deadband_power = psc_pkg::POWER_MAX;
    apply_settings(s);
    send_fields(0, 1, 1000, 500, 100);
    send_fields(0, 1, 1000, 900, 100);
    send_fields(0, 1, 1000, 1200, 100);
    send_fields(1, 1, -5, 0, 7);
    send_fields(0, 0, 1000, 900, 10);
    send_fields(0, 1, 1000, 900, 10);
  endtask

  task automatic test_register_extremes();
    psc_pkg::cfg_t s;
    s.gain_p = '1;
    s.gain_i = '1;
    s.gain_d = '1;
    s.integral_limit = '1;
    s.ramp_rate = '1;
    s.deadband_power = '1;
    s.deadband_speed = '1;
    s.overload_level = '1;
    apply_settings(s);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    run_control(PHASE_ITEMS);
    apply_settings('0);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    run_control(PHASE_ITEMS);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 6; k++) begin
      apply_settings((k == 0) ? psc_pkg::CFG_RESET : random_settings());
      tx_idle = (k % 3 != 1);
      rx_idle = (k % 3 != 2);
      run_control(PHASE_ITEMS);
    end
  endtask

  // receiver holds off while the sender keeps going, so the pipe fills and stalls
  task automatic test_output_holdoff();
    settle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_len = 400;
    for (int i = 0; i < 60; i++) send_tick(noise_tick());
    settle();
  endtask

  initial begin
    for (int c = 0; c < psc_pkg::CHANNELS; c++) begin
      ramp_fx[c] = 0;
      err_acc[c] = 0;
      err_prev[c] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_ticks();
    test_register_extremes();
    test_random_settings();
    test_output_holdoff();
    settle();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/psc_pkg.sv
design/psc_cfg.sv
design/psc_update.sv
design/psc_mult.sv
design/psc_output.sv
design/pid_speed_controller.sv
tb/sv/pid_speed_controller_tb.sv
